@@ hdl/lcpa_pkg.sv @@
// ----------------------------------------------------------------------------
// LRU color palette allocator package
// Shared sizes, cell command and group result types, and the control states.
// ----------------------------------------------------------------------------
`default_nettype none

package lcpa_pkg;

  localparam int SLOTS   = 256;
  localparam int COLOR_W = 32;
  localparam int IDX_W   = 8;
  localparam int RANK_W  = 8;
  localparam int CAP_W   = 9;
  localparam int GRP     = 16;
  localparam int NGRP    = (SLOTS + GRP - 1) / GRP;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_HIT,
    OP_FILL,
    OP_EVICT
  } cell_op_t;

  typedef struct packed {
    cell_op_t             op;
    logic [COLOR_W-1:0]   color;
    logic [IDX_W-1:0]     target;
    logic [RANK_W-1:0]    ref_rank;
    logic [RANK_W-1:0]    top;
  } cell_cmd_t;

  typedef struct packed {
    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;
    logic [RANK_W-1:0]    hit_rank;
    logic [IDX_W-1:0]     vic_idx;
  } grp_res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_RED,
    S_UPD
  } state_t;

endpackage

`default_nettype wire

@@ hdl/lcpa_cell.sv @@
// ----------------------------------------------------------------------------
// Palette cell
// Holds one slot's color, recency rank and filled bit, compares the lookup
// color and applies the broadcast update command.
// ----------------------------------------------------------------------------
`default_nettype none

module lcpa_cell (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [lcpa_pkg::IDX_W-1:0]   cell_idx,
  input  wire lcpa_pkg::cell_cmd_t          cmd,
  input  wire logic [lcpa_pkg::COLOR_W-1:0] look_color,
  output logic                              match,
  output logic                              victim,
  output logic [lcpa_pkg::RANK_W-1:0]       rank
);

  logic                         filled;
  logic [lcpa_pkg::COLOR_W-1:0] color;
  logic                         sel;

  assign sel    = (cmd.target == cell_idx);
  assign match  = filled && (color == look_color);
  assign victim = filled && (rank == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= 1'b0;
      rank   <= '0;
    end else begin
      case (cmd.op)
        lcpa_pkg::OP_CLEAR: begin
          filled <= 1'b0;
          rank   <= '0;
        end
        lcpa_pkg::OP_HIT: begin
          if (filled) begin
            if (sel) begin
              rank <= cmd.top;
            end else if (rank > cmd.ref_rank) begin
              rank <= rank - lcpa_pkg::RANK_W'(1);
            end
          end
        end
        lcpa_pkg::OP_FILL: begin
          if (sel) begin
            filled <= 1'b1;
            rank   <= cmd.ref_rank;
          end
        end
        lcpa_pkg::OP_EVICT: begin
          // Every filled slot but the victim ages by one; the victim becomes most recent.
          if (filled) begin
            if (sel) begin
              rank <= cmd.top;
            end else begin
              rank <= rank - lcpa_pkg::RANK_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sel && (cmd.op == lcpa_pkg::OP_FILL || cmd.op == lcpa_pkg::OP_EVICT)) begin
      color <= cmd.color;
    end
  end

endmodule

`default_nettype wire

@@ hdl/lcpa_group.sv @@
// ----------------------------------------------------------------------------
// Palette cell group
// A row of cells with a registered reduction of their hit and victim flags.
// ----------------------------------------------------------------------------
`default_nettype none

module lcpa_group (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [lcpa_pkg::IDX_W-1:0]   grp_base,
  input  wire lcpa_pkg::cell_cmd_t          cmd,
  input  wire logic [lcpa_pkg::COLOR_W-1:0] look_color,
  output lcpa_pkg::grp_res_t                res
);

  logic [lcpa_pkg::GRP-1:0]    match;
  logic [lcpa_pkg::GRP-1:0]    victim;
  logic [lcpa_pkg::RANK_W-1:0] rank [lcpa_pkg::GRP];
  logic [lcpa_pkg::IDX_W-1:0]  idx  [lcpa_pkg::GRP];
  lcpa_pkg::grp_res_t          res_next;

  for (genvar k = 0; k < lcpa_pkg::GRP; k++) begin : g_cell
    assign idx[k] = grp_base + lcpa_pkg::IDX_W'(k);

    lcpa_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_idx   (idx[k]),
      .cmd        (cmd),
      .look_color (look_color),
      .match      (match[k]),
      .victim     (victim[k]),
      .rank       (rank[k])
    );
  end

  // Colors are unique among filled slots and ranks form a permutation, so at
  // most one cell raises each flag and a plain OR collects its fields.
  always_comb begin
    res_next = '0;
    for (int k = 0; k < lcpa_pkg::GRP; k++) begin
      res_next.hit      = res_next.hit | match[k];
      res_next.hit_idx  = res_next.hit_idx  | (match[k]  ? idx[k]  : '0);
      res_next.hit_rank = res_next.hit_rank | (match[k]  ? rank[k] : '0);
      res_next.vic_idx  = res_next.vic_idx  | (victim[k] ? idx[k]  : '0);
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

`default_nettype wire

@@ hdl/lru_color_palette_allocator.sv @@
// ----------------------------------------------------------------------------
// LRU color palette allocator: returns the slot and hit flag for each accepted color.
// One transaction at a time: cell compare, group reduce, palette reduce/update.
// Reset empties the palette (filled bits cleared) and sets capacity to 256.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_color_palette_allocator (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wr_en,
  input  wire logic [lcpa_pkg::CAP_W-1:0]   cfg_wr_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [lcpa_pkg::COLOR_W-1:0] color,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [lcpa_pkg::IDX_W-1:0]        slot,
  output logic                              hit
);

  lcpa_pkg::state_t           state;
  lcpa_pkg::state_t           state_next;
  lcpa_pkg::cell_cmd_t        cmd;
  lcpa_pkg::grp_res_t         grp_res [lcpa_pkg::NGRP];
  lcpa_pkg::grp_res_t         red_next;
  lcpa_pkg::grp_res_t         red;
  logic [lcpa_pkg::COLOR_W-1:0] look_color;
  logic [lcpa_pkg::CAP_W-1:0] filled_count;
  logic [lcpa_pkg::CAP_W-1:0] capacity;
  logic [lcpa_pkg::CAP_W-1:0] count_dec;
  logic [lcpa_pkg::IDX_W-1:0] res_slot;
  logic                       room;
  logic                       can_out;
  logic                       upd_fire;
  logic                       cfg_ok;

  for (genvar g = 0; g < lcpa_pkg::NGRP; g++) begin : g_grp
    lcpa_group u_group (
      .clk        (clk),
      .rst        (rst),
      .grp_base   (lcpa_pkg::IDX_W'(g * lcpa_pkg::GRP)),
      .cmd        (cmd),
      .look_color (look_color),
      .res        (grp_res[g])
    );
  end

  assign can_out   = !out_valid || out_ready;
  assign upd_fire  = (state == lcpa_pkg::S_UPD) && can_out;
  assign room      = (filled_count < capacity);
  assign count_dec = filled_count - lcpa_pkg::CAP_W'(1);
  assign res_slot  = red.hit ? red.hit_idx :
                     (room ? filled_count[lcpa_pkg::IDX_W-1:0] : red.vic_idx);

  // Out-of-range values and a rewrite of the current capacity leave the
  // palette untouched.
  assign cfg_ok = cfg_wr_en && (cfg_wr_data != '0) &&
                  (cfg_wr_data <= lcpa_pkg::CAP_W'(lcpa_pkg::SLOTS)) &&
                  (cfg_wr_data != capacity);

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      lcpa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = lcpa_pkg::S_CMP;
        end
      end
      lcpa_pkg::S_CMP: state_next = lcpa_pkg::S_RED;
      lcpa_pkg::S_RED: state_next = lcpa_pkg::S_UPD;
      lcpa_pkg::S_UPD: begin
        if (can_out) begin
          in_ready   = 1'b1;
          state_next = in_valid ? lcpa_pkg::S_CMP : lcpa_pkg::S_IDLE;
        end
      end
      default: state_next = lcpa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcpa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    red_next = '0;
    for (int g = 0; g < lcpa_pkg::NGRP; g++) begin
      red_next.hit      = red_next.hit      | grp_res[g].hit;
      red_next.hit_idx  = red_next.hit_idx  | grp_res[g].hit_idx;
      red_next.hit_rank = red_next.hit_rank | grp_res[g].hit_rank;
      red_next.vic_idx  = red_next.vic_idx  | grp_res[g].vic_idx;
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.op       = lcpa_pkg::OP_NONE;
    cmd.color    = look_color;
    cmd.top      = count_dec[lcpa_pkg::RANK_W-1:0];
    cmd.ref_rank = red.hit_rank;
    cmd.target   = res_slot;
    if (cfg_ok) begin
      cmd.op = lcpa_pkg::OP_CLEAR;
    end else if (upd_fire) begin
      if (red.hit) begin
        cmd.op = lcpa_pkg::OP_HIT;
      end else if (room) begin
        cmd.op       = lcpa_pkg::OP_FILL;
        cmd.ref_rank = filled_count[lcpa_pkg::RANK_W-1:0];
      end else begin
        cmd.op = lcpa_pkg::OP_EVICT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      look_color <= color;
    end
    if (state == lcpa_pkg::S_RED) begin
      red <= red_next;
    end
    if (upd_fire) begin
      slot <= res_slot;
      hit  <= red.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled_count <= '0;
      capacity     <= lcpa_pkg::CAP_W'(lcpa_pkg::SLOTS);
      out_valid    <= 1'b0;
    end else begin
      if (cfg_ok) begin
        capacity     <= cfg_wr_data;
        filled_count <= '0;
      end else if (upd_fire && !red.hit && room) begin
        filled_count <= filled_count + lcpa_pkg::CAP_W'(1);
      end
      if (upd_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_count_le_cap: assert property (@(posedge clk) disable iff (rst)
    filled_count <= capacity)
    else $error("filled count exceeds capacity");

  a_accept_to_cmp: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == lcpa_pkg::S_CMP))
    else $error("accepted transaction did not start a compare");

  a_hit_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (upd_fire && red.hit && !cfg_ok) |=> (filled_count == $past(filled_count)))
    else $error("hit changed the filled count");

  a_slot_filled: assert property (@(posedge clk) disable iff (rst)
    (upd_fire && !cfg_ok) |=> ({1'b0, slot} < filled_count))
    else $error("result slot is not a filled slot");
`endif

endmodule

`default_nettype wire
